>>> sv/wpip_pkg.sv
// ============================================================================
// wpip_pkg
// Shared types and constants for the winding-number point-in-polygon block.
// ============================================================================
package wpip_pkg;

    // Default coordinate width of the query point and the vertices
    localparam int COORD_WIDTH_DEF = 16;

    // Width of the tolerance register
    localparam int TOL_WIDTH = 8;

    // Width of the half-unit winding count
    localparam int HALF_WIDTH = 11;

    typedef logic signed [HALF_WIDTH-1:0] halves_t;

    // Per-edge classification handed from the evaluate stage to the accumulator
    typedef struct packed {
        logic              cross_case;  // edge ends lie strictly on both sides of the ray
        logic              dir_down;    // start point lies above the ray
        logic signed [1:0] ray_halves;  // contribution of an end touching the ray
    } edge_flags_t;

endpackage

>>> sv/wpip_in_if.sv
// ============================================================================
// wpip_in_if
// Request channel: query point and one polygon vertex per request.
// ============================================================================
interface wpip_in_if #(
    parameter int CW = wpip_pkg::COORD_WIDTH_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] vertex_x;
    logic signed [CW-1:0] vertex_y;
    logic                 last_vertex;

    modport source (
        output valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
        output ready
    );
endinterface

>>> sv/wpip_out_if.sv
// ============================================================================
// wpip_out_if
// Result channel: inside bit and winding count in half units.
// ============================================================================
interface wpip_out_if;
    logic              valid;
    logic              ready;
    logic              inside_res;
    wpip_pkg::halves_t winding_halves;

    modport source (
        output valid, inside_res, winding_halves,
        input  ready
    );

    modport sink (
        input  valid, inside_res, winding_halves,
        output ready
    );
endinterface

>>> sv/wpip_edge_track.sv
// ============================================================================
// wpip_edge_track
// Input stage: keeps the first and previous vertex of the open polygon and
// registers the endpoints of the edges that each request completes.
// ============================================================================
module wpip_edge_track #(
    parameter int CW = wpip_pkg::COORD_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW-1:0] point_x,
    input  logic signed [CW-1:0] point_y,
    input  logic signed [CW-1:0] vertex_x,
    input  logic signed [CW-1:0] vertex_y,
    input  logic                 last_vertex,
    input  logic                 next_load,
    output logic                 a_valid,
    output logic                 a_last,
    output logic                 a_open_en,
    output logic signed [CW-1:0] a_px,
    output logic signed [CW-1:0] a_py,
    output logic signed [CW-1:0] a_prev_x,
    output logic signed [CW-1:0] a_prev_y,
    output logic signed [CW-1:0] a_cur_x,
    output logic signed [CW-1:0] a_cur_y,
    output logic signed [CW-1:0] a_first_x,
    output logic signed [CW-1:0] a_first_y
);

    logic                 a_valid_reg;
    logic                 a_last_reg;
    logic                 a_open_en_reg;
    logic signed [CW-1:0] a_px_reg;
    logic signed [CW-1:0] a_py_reg;
    logic signed [CW-1:0] a_prev_x_reg;
    logic signed [CW-1:0] a_prev_y_reg;
    logic signed [CW-1:0] a_cur_x_reg;
    logic signed [CW-1:0] a_cur_y_reg;
    logic signed [CW-1:0] a_first_x_reg;
    logic signed [CW-1:0] a_first_y_reg;

    logic                 in_polygon_reg;
    logic signed [CW-1:0] first_vx_reg;
    logic signed [CW-1:0] first_vy_reg;
    logic signed [CW-1:0] prev_vx_reg;
    logic signed [CW-1:0] prev_vy_reg;

    logic                 accept;
    logic signed [CW-1:0] first_x_next;
    logic signed [CW-1:0] first_y_next;

    // Take a request when the stage is empty or drains this cycle
    assign in_ready = !a_valid_reg || next_load;
    assign accept   = in_valid && in_ready;

    // A polygon opened by this vertex closes onto the vertex itself
    assign first_x_next = in_polygon_reg ? first_vx_reg : vertex_x;
    assign first_y_next = in_polygon_reg ? first_vy_reg : vertex_y;

    // Hold polygon tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_polygon_reg <= 1'b0;
            first_vx_reg   <= '0;
            first_vy_reg   <= '0;
            prev_vx_reg    <= '0;
            prev_vy_reg    <= '0;
        end
        else if (accept)
        begin
            in_polygon_reg <= !last_vertex;
            first_vx_reg   <= first_x_next;
            first_vy_reg   <= first_y_next;
            prev_vx_reg    <= vertex_x;
            prev_vy_reg    <= vertex_y;
        end
    end

    // Advance the stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    // Capture the edge endpoints of an accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_last_reg    <= last_vertex;
            a_open_en_reg <= in_polygon_reg;
            a_px_reg      <= point_x;
            a_py_reg      <= point_y;
            a_prev_x_reg  <= prev_vx_reg;
            a_prev_y_reg  <= prev_vy_reg;
            a_cur_x_reg   <= vertex_x;
            a_cur_y_reg   <= vertex_y;
            a_first_x_reg <= first_x_next;
            a_first_y_reg <= first_y_next;
        end
    end

    assign a_valid   = a_valid_reg;
    assign a_last    = a_last_reg;
    assign a_open_en = a_open_en_reg;
    assign a_px      = a_px_reg;
    assign a_py      = a_py_reg;
    assign a_prev_x  = a_prev_x_reg;
    assign a_prev_y  = a_prev_y_reg;
    assign a_cur_x   = a_cur_x_reg;
    assign a_cur_y   = a_cur_y_reg;
    assign a_first_x = a_first_x_reg;
    assign a_first_y = a_first_y_reg;

endmodule

>>> sv/wpip_edge_eval.sv
// ============================================================================
// wpip_edge_eval
// Evaluate stage for one edge: offsets from the query point, the two cross
// product terms and the on-ray classification; terms and flags registered.
// ============================================================================
module wpip_edge_eval #(
    parameter int CW = wpip_pkg::COORD_WIDTH_DEF,
    localparam int DW = CW + 1,
    localparam int PW = 2 * DW
) (
    input  logic                                 clk,
    input  logic                                 load,
    input  logic                                 en,
    input  logic signed [CW-1:0]                 ax,
    input  logic signed [CW-1:0]                 ay,
    input  logic signed [CW-1:0]                 bx,
    input  logic signed [CW-1:0]                 by,
    input  logic signed [CW-1:0]                 px,
    input  logic signed [CW-1:0]                 py,
    input  logic [wpip_pkg::TOL_WIDTH-1:0]       tol,
    output logic signed [PW-1:0]                 prod_a,
    output logic signed [PW-1:0]                 prod_b,
    output wpip_pkg::edge_flags_t                flags
);

    logic signed [DW-1:0]  xi;
    logic signed [DW-1:0]  yi;
    logic signed [DW-1:0]  xi1;
    logic signed [DW-1:0]  yi1;
    logic [DW-1:0]         yi_mag;
    logic [DW-1:0]         yi1_mag;
    logic [DW-1:0]         tol_ext;
    logic                  yi_neg;
    logic                  yi_pos;
    logic                  yi1_neg;
    logic                  yi1_pos;
    logic                  xi_pos;
    logic                  xi1_pos;
    logic                  nz_yi;
    logic                  nz_yi1;
    logic signed [PW-1:0]  prod_a_next;
    logic signed [PW-1:0]  prod_b_next;
    wpip_pkg::edge_flags_t flags_next;

    logic signed [PW-1:0]  prod_a_reg;
    logic signed [PW-1:0]  prod_b_reg;
    wpip_pkg::edge_flags_t flags_reg;

    // Offsets of both endpoints from the query point
    assign xi  = $signed({ax[CW-1], ax}) - $signed({px[CW-1], px});
    assign yi  = $signed({ay[CW-1], ay}) - $signed({py[CW-1], py});
    assign xi1 = $signed({bx[CW-1], bx}) - $signed({px[CW-1], px});
    assign yi1 = $signed({by[CW-1], by}) - $signed({py[CW-1], py});

    // Signs and magnitudes
    assign yi_neg  = yi[DW-1];
    assign yi_pos  = !yi[DW-1] && (|yi);
    assign yi1_neg = yi1[DW-1];
    assign yi1_pos = !yi1[DW-1] && (|yi1);
    assign xi_pos  = !xi[DW-1] && (|xi);
    assign xi1_pos = !xi1[DW-1] && (|xi1);
    assign yi_mag  = yi_neg ? (~yi + 1'b1) : yi;
    assign yi1_mag = yi1_neg ? (~yi1 + 1'b1) : yi1;
    assign tol_ext = {{(DW - wpip_pkg::TOL_WIDTH){1'b0}}, tol};
    assign nz_yi   = (yi_mag <= tol_ext);
    assign nz_yi1  = (yi1_mag <= tol_ext);

    // Cross product terms yi*xi1 and xi*yi1
    assign prod_a_next = yi * xi1;
    assign prod_b_next = xi * yi1;

    // Classify the edge against the ray towards +x
    always_comb
    begin
        flags_next            = '0;
        flags_next.cross_case = (yi_neg && yi1_pos) || (yi_pos && yi1_neg);
        flags_next.dir_down   = yi_pos;
        if (flags_next.cross_case)
        begin
            flags_next.ray_halves = 2'sd0;
        end
        else if (nz_yi && xi_pos)
        begin
            if (nz_yi1)
                flags_next.ray_halves = 2'sd0;
            else
                flags_next.ray_halves = yi1_pos ? 2'sd1 : -2'sd1;
        end
        else if (nz_yi1 && xi1_pos)
        begin
            if (nz_yi)
                flags_next.ray_halves = 2'sd0;
            else
                flags_next.ray_halves = yi_neg ? 2'sd1 : -2'sd1;
        end
        else
        begin
            flags_next.ray_halves = 2'sd0;
        end
        // Drop the edge entirely when it does not exist
        if (!en)
        begin
            flags_next = '0;
        end
    end

    // Register products and classification
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            flags_reg  <= flags_next;
        end
    end

    assign prod_a = prod_a_reg;
    assign prod_b = prod_b_reg;
    assign flags  = flags_reg;

endmodule

>>> sv/wpip_accum.sv
// ============================================================================
// wpip_accum
// Accumulate stage: resolves the crossing sign of both edges, adds their
// contributions to the saturating winding count and holds the result.
// ============================================================================
module wpip_accum #(
    parameter int CW = wpip_pkg::COORD_WIDTH_DEF,
    localparam int PW = 2 * (CW + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  a_valid,
    input  logic                  a_last,
    output logic                  b_load,
    input  logic signed [PW-1:0]  open_prod_a,
    input  logic signed [PW-1:0]  open_prod_b,
    input  wpip_pkg::edge_flags_t open_flags,
    input  logic signed [PW-1:0]  close_prod_a,
    input  logic signed [PW-1:0]  close_prod_b,
    input  wpip_pkg::edge_flags_t close_flags,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  inside_res,
    output wpip_pkg::halves_t     winding_halves
);

    localparam int HW = wpip_pkg::HALF_WIDTH;
    localparam logic signed [HW:0] SumMax = (HW+1)'((1 << (HW - 1)) - 1);
    localparam logic signed [HW:0] SumMin = -(HW+1)'(1 << (HW - 1));

    logic              b_valid_reg;
    logic              b_last_reg;
    wpip_pkg::halves_t half_count_reg;
    logic              out_valid_reg;
    logic              inside_reg;
    wpip_pkg::halves_t winding_reg;

    logic              c_stall;
    logic              b_fire;
    logic signed [2:0] open_d;
    logic signed [2:0] close_d;
    wpip_pkg::halves_t sum_open;
    wpip_pkg::halves_t sum_close;
    logic              inside_next;

    // Contribution of one edge in half units
    function automatic logic signed [2:0] edge_delta(
        input logic signed [PW-1:0]  pa,
        input logic signed [PW-1:0]  pb,
        input wpip_pkg::edge_flags_t fl
    );
        logic signed [PW:0] diff;
        logic               hit;
        logic signed [2:0]  d;
        diff = $signed({pa[PW-1], pa}) - $signed({pb[PW-1], pb});
        hit  = fl.dir_down ? (!diff[PW] && (|diff)) : diff[PW];
        if (fl.cross_case)
            d = hit ? (fl.dir_down ? -3'sd2 : 3'sd2) : 3'sd0;
        else
            d = 3'(fl.ray_halves);
        return d;
    endfunction

    // Add with clamping to the count range
    function automatic wpip_pkg::halves_t sat_add(
        input wpip_pkg::halves_t acc,
        input logic signed [2:0] d
    );
        logic signed [HW:0] s;
        s = $signed({acc[HW-1], acc}) + (HW+1)'(d);
        if (s > SumMax)
            s = SumMax;
        else if (s < SumMin)
            s = SumMin;
        return s[HW-1:0];
    endfunction

    // Hold only a final vertex that finds the result register occupied
    assign c_stall = b_valid_reg && b_last_reg && out_valid_reg && !out_ready;
    assign b_fire  = b_valid_reg && !c_stall;
    assign b_load  = !b_valid_reg || !c_stall;

    // Edge contributions, the opening edge first
    assign open_d    = edge_delta(open_prod_a, open_prod_b, open_flags);
    assign close_d   = edge_delta(close_prod_a, close_prod_b, close_flags);
    assign sum_open  = sat_add(half_count_reg, open_d);
    assign sum_close = sat_add(sum_open, close_d);

    // Inside when the halved magnitude is odd
    assign inside_next = sum_close[HW-1] ? (sum_close[1] ^ sum_close[0]) : sum_close[1];

    // Advance the evaluate stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_load)
        begin
            b_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_last_reg <= a_last;
        end
    end

    // Update the running count; restart after a final vertex
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_count_reg <= '0;
        end
        else if (b_fire)
        begin
            half_count_reg <= b_last_reg ? '0 : sum_close;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (b_fire && b_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire && b_last_reg)
        begin
            inside_reg  <= inside_next;
            winding_reg <= sum_close;
        end
    end

    assign out_valid      = out_valid_reg;
    assign inside_res     = inside_reg;
    assign winding_halves = winding_reg;

endmodule

>>> sv/winding_point_in_polygon_top.sv
// ============================================================================
// winding_point_in_polygon_top
// Streaming winding-number point-in-polygon test with a configurable
// zero tolerance for the on-ray tests.
// ============================================================================
// Send one request per polygon vertex, each carrying the query point; mark
// the final vertex with last_vertex. The block takes one request every
// cycle unless a final vertex holds at the accumulate stage, and gives one
// result per polygon. The request passes an input register, an evaluate
// register after the two parallel cross-product multiplier pairs (one pair
// for the edge from the previous vertex, one for the closing edge), and the
// result register after the accumulate logic. Requests keep flowing while a
// result waits; only the final vertex of the next polygon holds at the
// accumulate stage until the waiting result is taken. The winding count is
// in half units and saturates at its 11-bit limits. Write zero_tolerance
// only while idle.
// ============================================================================
module winding_point_in_polygon_top #(
    parameter int COORD_WIDTH = wpip_pkg::COORD_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [wpip_pkg::TOL_WIDTH-1:0] cfg_wr_data,
    wpip_in_if.sink                        in_ch,
    wpip_out_if.source                     out_ch
);

    localparam int PW = 2 * (COORD_WIDTH + 1);

    logic [wpip_pkg::TOL_WIDTH-1:0] zero_tolerance_reg;

    logic                       b_load;
    logic                       a_valid;
    logic                       a_last;
    logic                       a_open_en;
    logic signed [COORD_WIDTH-1:0] a_px;
    logic signed [COORD_WIDTH-1:0] a_py;
    logic signed [COORD_WIDTH-1:0] a_prev_x;
    logic signed [COORD_WIDTH-1:0] a_prev_y;
    logic signed [COORD_WIDTH-1:0] a_cur_x;
    logic signed [COORD_WIDTH-1:0] a_cur_y;
    logic signed [COORD_WIDTH-1:0] a_first_x;
    logic signed [COORD_WIDTH-1:0] a_first_y;

    logic signed [PW-1:0]  open_prod_a;
    logic signed [PW-1:0]  open_prod_b;
    wpip_pkg::edge_flags_t open_flags;
    logic signed [PW-1:0]  close_prod_a;
    logic signed [PW-1:0]  close_prod_b;
    wpip_pkg::edge_flags_t close_flags;

    // Tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_tolerance_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            zero_tolerance_reg <= cfg_wr_data;
        end
    end

    // Input register and polygon tracking
    wpip_edge_track #(
        .CW (COORD_WIDTH)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_ch.valid),
        .in_ready    (in_ch.ready),
        .point_x     (in_ch.point_x),
        .point_y     (in_ch.point_y),
        .vertex_x    (in_ch.vertex_x),
        .vertex_y    (in_ch.vertex_y),
        .last_vertex (in_ch.last_vertex),
        .next_load   (b_load),
        .a_valid     (a_valid),
        .a_last      (a_last),
        .a_open_en   (a_open_en),
        .a_px        (a_px),
        .a_py        (a_py),
        .a_prev_x    (a_prev_x),
        .a_prev_y    (a_prev_y),
        .a_cur_x     (a_cur_x),
        .a_cur_y     (a_cur_y),
        .a_first_x   (a_first_x),
        .a_first_y   (a_first_y)
    );

    // Edge from the previous vertex to the current one
    wpip_edge_eval #(
        .CW (COORD_WIDTH)
    ) u_eval_open (
        .clk    (clk),
        .load   (b_load),
        .en     (a_open_en),
        .ax     (a_prev_x),
        .ay     (a_prev_y),
        .bx     (a_cur_x),
        .by     (a_cur_y),
        .px     (a_px),
        .py     (a_py),
        .tol    (zero_tolerance_reg),
        .prod_a (open_prod_a),
        .prod_b (open_prod_b),
        .flags  (open_flags)
    );

    // Closing edge from the current vertex back to the first
    wpip_edge_eval #(
        .CW (COORD_WIDTH)
    ) u_eval_close (
        .clk    (clk),
        .load   (b_load),
        .en     (a_last),
        .ax     (a_cur_x),
        .ay     (a_cur_y),
        .bx     (a_first_x),
        .by     (a_first_y),
        .px     (a_px),
        .py     (a_py),
        .tol    (zero_tolerance_reg),
        .prod_a (close_prod_a),
        .prod_b (close_prod_b),
        .flags  (close_flags)
    );

    // Count accumulation and result register
    wpip_accum #(
        .CW (COORD_WIDTH)
    ) u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .a_valid        (a_valid),
        .a_last         (a_last),
        .b_load         (b_load),
        .open_prod_a    (open_prod_a),
        .open_prod_b    (open_prod_b),
        .open_flags     (open_flags),
        .close_prod_a   (close_prod_a),
        .close_prod_b   (close_prod_b),
        .close_flags    (close_flags),
        .out_ready      (out_ch.ready),
        .out_valid      (out_ch.valid),
        .inside_res     (out_ch.inside_res),
        .winding_halves (out_ch.winding_halves)
    );

endmodule

>>> sv/wpip_checker.sv
// ============================================================================
// wpip_checker
// Port-level checks for the point-in-polygon block, bound to the top level.
// ============================================================================
module wpip_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic                     inside_res,
    input wpip_pkg::halves_t        winding_halves
);

    // Hold a stalled result steady
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(winding_halves)
            && $stable(inside_res))
        else $error("result changed while stalled");

    // Accept requests whenever no result is waiting
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request refused with empty result register");

    // Inside bit follows a non-negative count
    a_inside_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !winding_halves[wpip_pkg::HALF_WIDTH-1]
            |-> inside_res == winding_halves[1])
        else $error("inside bit wrong for non-negative count");

    // Inside bit follows the magnitude of a negative count
    a_inside_neg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && winding_halves[wpip_pkg::HALF_WIDTH-1]
            |-> inside_res == (winding_halves[1] ^ winding_halves[0]))
        else $error("inside bit wrong for negative count");

endmodule

bind winding_point_in_polygon_top wpip_checker u_wpip_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .inside_res     (out_ch.inside_res),
    .winding_halves (out_ch.winding_halves)
);
